@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands included by padded_pixel_store_edge_replicate
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/ppse_pkg.sv @@
// ----------------------------------------------------------------------------
// ppse_pkg
// Shared constants for the padded pixel store
// ----------------------------------------------------------------------------
package ppse_pkg;

  // stored surface limits
  localparam int MAX_STORED_W = 128;
  localparam int MAX_STORED_H = 128;
  localparam int STORE_DEPTH  = MAX_STORED_W * MAX_STORED_H;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int TEXEL_W      = 32;

  // commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_RAW   = 2'd2;

  // pad modes
  localparam logic [1:0] PAD_NONE   = 2'd0;
  localparam logic [1:0] PAD_REPEAT = 2'd1;
  localparam logic [1:0] PAD_CLAMP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CONTENT_W = 2'd0;
  localparam logic [1:0] REG_CONTENT_H = 2'd1;
  localparam logic [1:0] REG_PAD_MODE  = 2'd2;

  // write slots: main texel plus up to eight border copies
  localparam int          NUM_SLOTS = 9;
  localparam logic [3:0]  SLOT_MAIN = 4'd0;
  localparam logic [3:0]  SLOT_FC   = 4'd1;
  localparam logic [3:0]  SLOT_LC   = 4'd2;
  localparam logic [3:0]  SLOT_FR   = 4'd3;
  localparam logic [3:0]  SLOT_LR   = 4'd4;
  localparam logic [3:0]  SLOT_FCFR = 4'd5;
  localparam logic [3:0]  SLOT_LCLR = 4'd6;
  localparam logic [3:0]  SLOT_LCFR = 4'd7;
  localparam logic [3:0]  SLOT_FCLR = 4'd8;
  localparam logic [NUM_SLOTS-1:0] MASK_MAIN = 9'b0_0000_0001;

endpackage

@@ rtl/ppse_ram.sv @@
// ----------------------------------------------------------------------------
// ppse_ram
// Simple dual port synchronous RAM with a registered read port
// ----------------------------------------------------------------------------
module ppse_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/padded_pixel_store_edge_replicate.sv @@
// ----------------------------------------------------------------------------
// padded_pixel_store_edge_replicate
// Texel store with a one texel guard border kept in repeat or clamp form
// ----------------------------------------------------------------------------
// sequence: a read passes through the read, read wait and done states, a write
//   through one write state per texel write (1 to 9) and then done, and an error or
//   unknown command straight to done; one request at a time, the next is taken only
//   after done has passed its result to the output register, later while out stalls
// reset: synchronous active low; clears control, the transparency flag and
//   the configuration to 126 x 126 with no border; texel memory is not cleared
module padded_pixel_store_edge_replicate (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_coord, y_coord, red, green, blue, alpha
  input  logic [1:0]  in_tuser,   // command
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_red, read_green, read_blue, read_alpha, has_transparency, range_error
  output logic [39:0] out_tdata,
  // configuration port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  import ppse_pkg::*;

  `include "assert_macros.svh"

  // state codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WRITE  = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [8:0] MAX_W_LIM = 9'(MAX_STORED_W);
  localparam logic [8:0] MAX_H_LIM = 9'(MAX_STORED_H);

  logic [2:0]           state_r, state_nxt;
  logic [7:0]           cw_r, ch_r;
  logic [1:0]           pad_r;
  logic                 trans_r, trans_nxt;
  logic [6:0]           col_r, row_r;
  logic [7:0]           sw_r, sh_r;
  logic                 repeat_r;
  logic [TEXEL_W-1:0]   texel_r;
  logic [NUM_SLOTS-1:0] mask_r, mask_nxt;
  logic [TEXEL_W-1:0]   res_texel_r, res_texel_nxt;
  logic                 res_err_r, res_err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [39:0]          out_data_r, out_data_nxt;

  // request fields
  logic [1:0] in_cmd;
  logic [6:0] in_x, in_y;
  logic [TEXEL_W-1:0] in_texel;
  logic [7:0] in_alpha;

  assign in_cmd   = in_tuser;
  assign in_x     = in_tdata[6:0];
  assign in_y     = in_tdata[13:7];
  assign in_texel = in_tdata[45:14];
  assign in_alpha = in_tdata[45:38];

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // request decode: stored size, coordinate shift, bounds and border copies
  logic                 padded, edges_on, shift, cmd_valid, usable, acc_err;
  logic [8:0]           sw_full, sh_full;
  logic [7:0]           col_ext, row_ext;
  logic                 first_c, last_c, first_r, last_r;
  logic [NUM_SLOTS-1:0] acc_mask;

  always_comb begin
    padded    = (pad_r != PAD_NONE);
    edges_on  = (pad_r == PAD_REPEAT) || (pad_r == PAD_CLAMP);
    sw_full   = {1'b0, cw_r} + (padded ? 9'd2 : 9'd0);
    sh_full   = {1'b0, ch_r} + (padded ? 9'd2 : 9'd0);
    usable    = (cw_r != 8'd0) && (ch_r != 8'd0) &&
                (sw_full <= MAX_W_LIM) && (sh_full <= MAX_H_LIM);
    shift     = (in_cmd != CMD_RAW) && padded;
    col_ext   = {1'b0, in_x} + {7'd0, shift};
    row_ext   = {1'b0, in_y} + {7'd0, shift};
    cmd_valid = (in_cmd == CMD_WRITE) || (in_cmd == CMD_READ) || (in_cmd == CMD_RAW);
    acc_err   = cmd_valid && (!usable || ({1'b0, col_ext} >= sw_full) ||
                              ({1'b0, row_ext} >= sh_full));
    first_c   = edges_on && (col_ext == 8'd1);
    last_c    = edges_on && ({1'b0, col_ext} == sw_full - 9'd2);
    first_r   = edges_on && (row_ext == 8'd1);
    last_r    = edges_on && ({1'b0, row_ext} == sh_full - 9'd2);
    acc_mask  = MASK_MAIN;
    if (in_cmd == CMD_WRITE) begin
      acc_mask[SLOT_FC]   = first_c;
      acc_mask[SLOT_LC]   = last_c;
      acc_mask[SLOT_FR]   = first_r;
      acc_mask[SLOT_LR]   = last_r;
      acc_mask[SLOT_FCFR] = first_c && first_r;
      acc_mask[SLOT_LCLR] = last_c && last_r;
      acc_mask[SLOT_LCFR] = last_c && first_r;
      acc_mask[SLOT_FCLR] = first_c && last_r;
    end
  end

  // pick the lowest pending write slot
  logic [3:0] slot;
  always_comb begin
    slot = SLOT_MAIN;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        slot = 4'(i);
      end
    end
  end

  // slot coordinates and memory address
  logic [7:0]  lc, lr, ecf, ecl, erf, erl, col_sel, row_sel;
  logic [15:0] addr_full;
  logic [ADDR_W-1:0] mem_addr;

  always_comb begin
    lc  = sw_r - 8'd1;
    lr  = sh_r - 8'd1;
    ecf = repeat_r ? lc : 8'd0;
    ecl = repeat_r ? 8'd0 : lc;
    erf = repeat_r ? lr : 8'd0;
    erl = repeat_r ? 8'd0 : lr;
    col_sel = {1'b0, col_r};
    row_sel = {1'b0, row_r};
    case (slot)
      SLOT_FC:   col_sel = ecf;
      SLOT_LC:   col_sel = ecl;
      SLOT_FR:   row_sel = erf;
      SLOT_LR:   row_sel = erl;
      SLOT_FCFR: begin
        col_sel = ecf;
        row_sel = erf;
      end
      SLOT_LCLR: begin
        col_sel = ecl;
        row_sel = erl;
      end
      SLOT_LCFR: begin
        col_sel = ecl;
        row_sel = erf;
      end
      SLOT_FCLR: begin
        col_sel = ecf;
        row_sel = erl;
      end
      default: ;
    endcase
    addr_full = row_sel * sw_r + {8'd0, col_sel};
    mem_addr  = addr_full[ADDR_W-1:0];
  end

  // texel memory
  logic               mem_wr, mem_rd;
  logic [TEXEL_W-1:0] mem_rdata;

  assign mem_wr = (state_r == ST_WRITE);
  assign mem_rd = (state_r == ST_RD);

  ppse_ram #(
    .DATA_W(TEXEL_W),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_wr),
    .wr_addr(mem_addr),
    .wr_data(texel_r),
    .rd_en  (mem_rd),
    .rd_addr(mem_addr),
    .rd_data(mem_rdata)
  );

  // sequencer
  logic last_slot, out_free;
  assign last_slot = ((mask_r & (mask_r - 9'd1)) == '0);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    trans_nxt     = trans_r;
    res_texel_nxt = res_texel_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mask_nxt      = acc_mask;
          res_texel_nxt = '0;
          res_err_nxt   = acc_err;
          if (!cmd_valid || acc_err) begin
            state_nxt = ST_DONE;
          end else if (in_cmd == CMD_WRITE) begin
            state_nxt = ST_WRITE;
            if (in_alpha != 8'hFF) begin
              trans_nxt = 1'b1;
            end
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_WRITE: begin
        mask_nxt = mask_r & (mask_r - 9'd1);
        if (last_slot) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD: begin
        state_nxt = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        res_texel_nxt = mem_rdata;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, res_err_r, trans_r, res_texel_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      trans_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      trans_r     <= trans_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r  <= 8'd126;
      ch_r  <= 8'd126;
      pad_r <= PAD_NONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CONTENT_W: cw_r  <= cfg_wdata;
        REG_CONTENT_H: ch_r  <= cfg_wdata;
        REG_PAD_MODE:  pad_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // request payload captured at accept, sequencer data registered every cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_r    <= col_ext[6:0];
      row_r    <= row_ext[6:0];
      sw_r     <= sw_full[7:0];
      sh_r     <= sh_full[7:0];
      repeat_r <= (pad_r == PAD_REPEAT);
      texel_r  <= in_texel;
    end
    mask_r      <= mask_nxt;
    res_texel_r <= res_texel_nxt;
    res_err_r   <= res_err_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `ASSERT_NEXT(a_read_issues, clk, rst_n,
    in_acc && (in_cmd == CMD_READ || in_cmd == CMD_RAW) && !acc_err, state_r == ST_RD)
  `ASSERT_SAME(a_no_copies_unpadded, clk, rst_n,
    state_r == ST_WRITE && pad_r == PAD_NONE, mask_r == MASK_MAIN)
  `ASSERT_SAME(a_write_ends_onehot, clk, rst_n,
    state_r == ST_WRITE && state_nxt != ST_WRITE, $onehot(mask_r))
  `ASSERT_SAME(a_err_no_write, clk, rst_n,
    state_r == ST_WRITE, !res_err_r)

endmodule
